// ----- rtl/core/tbpc_pkg.sv -----
// Shared types and constants of the two-button press classifier.
`default_nettype none
package tbpc_pkg;

    localparam int unsigned CountW = 8;

    localparam logic [CountW-1:0] LimitReset = 8'd90;
    localparam logic [CountW-1:0] ShortMin   = 8'd1;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_ONE_SHORT  = 3'd1,
        EV_ONE_LONG   = 3'd2,
        EV_TWO_SHORT  = 3'd3,
        EV_TWO_LONG   = 3'd4,
        EV_BOTH_SHORT = 3'd5,
        EV_BOTH_LONG  = 3'd6
    } t_event;

    typedef struct packed {
        logic one;
        logic two;
    } t_buttons;

    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

endpackage
`default_nettype wire

// ----- rtl/core/tbpc_in_reg.sv -----
// Input register stage holding one button sample item.
`default_nettype none
module tbpc_in_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire tbpc_pkg::t_buttons i_buttons,
    input  wire                   i_advance,
    output tbpc_pkg::t_stage_ctl  o_ctl,
    output tbpc_pkg::t_buttons    o_buttons
);

    logic               r_valid;
    logic               n_valid;
    tbpc_pkg::t_buttons r_buttons;
    logic               w_take;

    assign o_ready = !r_valid || i_advance;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_buttons <= i_buttons;
        end
    end

    assign o_ctl.valid   = r_valid;
    assign o_ctl.advance = i_advance && r_valid;
    assign o_buttons     = r_buttons;

endmodule
`default_nettype wire

// ----- rtl/core/tbpc_eval.sv -----
// Hold counters, released flag, limit register and event decision.
`default_nettype none
module tbpc_eval (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_valid,
    input  wire  [7:0]              i_cfg_data,
    input  wire tbpc_pkg::t_stage_ctl i_ctl,
    input  wire tbpc_pkg::t_buttons i_buttons,
    output tbpc_pkg::t_event        o_event
);

    localparam int unsigned W = tbpc_pkg::CountW;
    localparam logic [W-1:0] CountStep = W'(1);

    logic [W-1:0] r_limit;
    logic [W-1:0] r_cnt_one;
    logic [W-1:0] r_cnt_two;
    logic [W-1:0] r_cnt_both;
    logic         r_released;

    logic [W-1:0] n_cnt_one;
    logic [W-1:0] n_cnt_two;
    logic [W-1:0] n_cnt_both;
    logic         n_released;

    logic         w_up;
    logic         w_long_one;
    logic         w_long_two;
    logic         w_long_both;
    logic         w_long_any;
    logic [W-1:0] w_one_a;
    logic [W-1:0] w_two_a;
    logic [W-1:0] w_both_a;
    logic         w_rel_a;

    always_comb begin
        w_up        = !i_buttons.one && !i_buttons.two;
        w_long_one  = r_cnt_one > r_limit;
        w_long_two  = r_cnt_two > r_limit;
        w_long_both = r_cnt_both > r_limit;
        w_long_any  = w_long_one || w_long_two || w_long_both;
        w_one_a     = w_long_one ? '0 : r_cnt_one;
        w_two_a     = w_long_two ? '0 : r_cnt_two;
        w_both_a    = w_long_both ? '0 : r_cnt_both;
        w_rel_a     = r_released && !w_long_any;

        o_event = tbpc_pkg::EV_NONE;
        if (w_long_one) begin
            o_event = tbpc_pkg::EV_ONE_LONG;
        end
        if (w_long_two) begin
            o_event = tbpc_pkg::EV_TWO_LONG;
        end
        if (w_long_both) begin
            o_event = tbpc_pkg::EV_BOTH_LONG;
        end
        if (w_up && (w_one_a > tbpc_pkg::ShortMin)) begin
            o_event = tbpc_pkg::EV_ONE_SHORT;
        end
        if (w_up && (w_two_a > tbpc_pkg::ShortMin)) begin
            o_event = tbpc_pkg::EV_TWO_SHORT;
        end
        if (w_up && (w_both_a > tbpc_pkg::ShortMin)) begin
            o_event = tbpc_pkg::EV_BOTH_SHORT;
        end

        if (i_buttons.one && !i_buttons.two && w_rel_a) begin
            n_cnt_one = w_one_a + CountStep;
        end else begin
            n_cnt_one = '0;
        end
        if (i_buttons.two && !i_buttons.one && w_rel_a) begin
            n_cnt_two = w_two_a + CountStep;
        end else begin
            n_cnt_two = '0;
        end
        if (w_up) begin
            n_cnt_both = '0;
        end else if (i_buttons.one && i_buttons.two && w_rel_a) begin
            n_cnt_both = w_both_a + CountStep;
        end else begin
            n_cnt_both = w_both_a;
        end
        n_released = w_up || w_rel_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= tbpc_pkg::LimitReset;
            r_cnt_one  <= '0;
            r_cnt_two  <= '0;
            r_cnt_both <= '0;
            r_released <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_ctl.advance) begin
                r_cnt_one  <= n_cnt_one;
                r_cnt_two  <= n_cnt_two;
                r_cnt_both <= n_cnt_both;
                r_released <= n_released;
            end
        end
    end

    a_single_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_cnt_one != '0) && (r_cnt_two != '0)))
        else $error("one and two counters active together");

    a_long_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.advance && w_long_any && !w_up) |=> !r_released)
        else $error("long event did not block counting");

    a_blocked_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_released |-> ((r_cnt_one == '0) && (r_cnt_two == '0)))
        else $error("single counter moved while blocked");

endmodule
`default_nettype wire

// ----- rtl/core/tbpc_out_reg.sv -----
// Result register holding one press event item toward the output.
`default_nettype none
module tbpc_out_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire tbpc_pkg::t_stage_ctl i_ctl,
    input  wire tbpc_pkg::t_event i_event,
    input  wire                   i_ready,
    output logic                  o_valid,
    output tbpc_pkg::t_event      o_event,
    output logic                  o_advance
);

    logic            r_valid;
    logic            n_valid;
    tbpc_pkg::t_event r_event;

    assign o_advance = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.advance) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_event <= i_event;
        end
    end

    assign o_valid = r_valid;
    assign o_event = r_event;

endmodule
`default_nettype wire

// ----- rtl/core/two_button_press_classifier_core.sv -----
// Top level of the two-button short/long press classifier.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    tdata[0] button_one, [1] button_two
//  m_axis    out        m_axis_tvalid/m_axis_tready    tdata[2:0] press_event
//  cfg       in         i_cfg_valid/o_cfg_ready        i_cfg_data long_press_limit
//
// One item per cycle sustained while m_axis_tready is high.
// Input register, one pass of counter/event logic, result register.
// Synchronous active-low reset: counters zero, released flag set, limit 90.
// A stalled output holds its item; the input register keeps accepting while
// the result register is free or being drained in the same cycle.
`default_nettype none
module two_button_press_classifier_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [0] button_one, [1] button_two
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [2:0] press_event
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire  [7:0] i_cfg_data
);

    tbpc_pkg::t_buttons   w_in_btn;
    tbpc_pkg::t_buttons   w_stage_btn;
    tbpc_pkg::t_stage_ctl w_ctl;
    tbpc_pkg::t_event     w_event;
    tbpc_pkg::t_event     w_out_event;
    logic                 w_advance;

    assign o_cfg_ready  = 1'b1;
    assign w_in_btn.one = s_axis_tdata[0];
    assign w_in_btn.two = s_axis_tdata[1];

    tbpc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_buttons (w_in_btn),
        .i_advance (w_advance),
        .o_ctl     (w_ctl),
        .o_buttons (w_stage_btn)
    );

    tbpc_eval u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (w_ctl),
        .i_buttons   (w_stage_btn),
        .o_event     (w_event)
    );

    tbpc_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_event   (w_event),
        .i_ready   (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_event   (w_out_event),
        .o_advance (w_advance)
    );

    assign m_axis_tdata = {5'b0, w_out_event};

endmodule
`default_nettype wire
